// ----- rtl/mpmu_pkg.sv -----
// ----------------------------------------------------------------------------
// mpmu_pkg
// Types, codes and command structs shared by the max-product message update.
// ----------------------------------------------------------------------------
package mpmu_pkg;

    typedef enum logic [1:0] {
        OP_LOAD_VEC  = 2'd0,
        OP_LOAD_POT  = 2'd1,
        OP_COMPUTE   = 2'd2,
        OP_UNUSED    = 2'd3
    } t_op;

    localparam logic CFG_NUM_STATES = 1'b0;
    localparam logic CFG_EPS_FLOOR  = 1'b1;

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  row;
        logic [3:0]  col;
        logic [31:0] belief_value;
        logic [31:0] old_message;
        logic [31:0] potential;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  state_index;
        logic [31:0] message_value;
        logic        last;
        logic        zero_peak;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TMP_RD,    // read belief/old for state x
        ST_TMP_DIV,   // divide (iterative)
        ST_MAC_RD,    // read potential[y][x]
        ST_MAC_MUL,   // product register
        ST_MAC_CMP,   // running max
        ST_ROW_END,   // store best for row y
        ST_NRM_RD,    // read new[y]
        ST_NRM_DIV,   // divide by peak
        ST_EMIT       // hold result beat
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic clr_x;
        logic inc_x;
        logic clr_y;
        logic inc_y;
        logic tmp_rd;
        logic div_start_tmp;
        logic div_start_nrm;
        logic tmp_wr;
        logic mac_rd;
        logic mul_en;
        logic cmp_en;
        logic row_wr;
        logic nrm_rd;
        logic emit_load;
        logic clr_peak;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic x_last;
        logic y_last;
        logic div_done;
    } t_sts;

endpackage

// ----- rtl/max_product_message_update.sv -----
// ----------------------------------------------------------------------------
// max_product_message_update
// Max-product message update for one edge, unsigned Q16.16.
// ----------------------------------------------------------------------------
// Loads (belief/old message, potential entry) are accepted whenever the block
// is idle. A compute beat runs through one shared 48-step bit-serial divider
// and one multiplier: a quotient per state, a potential product per entry of
// the table and a row store per row, then a normalization division per state,
// each result beat held until it is taken, all over the clamped state count.
// Results come out one beat per state, in state order, last marked.
module max_product_message_update #(
    parameter int MAX_STATES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  mpmu_pkg::t_in_item    i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output mpmu_pkg::t_out_item   o_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic                  i_cfg_index,
    input  logic [31:0]           i_cfg_data
);
    import mpmu_pkg::*;

    logic [4:0]  r_num_states;
    logic [15:0] r_eps_floor;
    t_cmd        w_cmd;
    t_sts        w_sts;
    logic        w_idle, w_acc, w_start, w_load_vec, w_load_pot;

    assign o_ready     = w_idle;
    assign o_cfg_ready = 1'b1;
    assign w_acc       = i_valid && w_idle;
    assign w_start     = w_acc && (i_data.operation == OP_COMPUTE);
    assign w_load_vec  = w_acc && (i_data.operation == OP_LOAD_VEC);
    assign w_load_pot  = w_acc && (i_data.operation == OP_LOAD_POT);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_states <= 5'd16;
            r_eps_floor  <= 16'd1;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_NUM_STATES) r_num_states <= i_cfg_data[4:0];
            else                               r_eps_floor  <= i_cfg_data[15:0];
        end
    end

    mpmu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_out_ready (i_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_idle      (w_idle),
        .o_out_valid (o_valid)
    );

    mpmu_datapath #(.MAX_STATES(MAX_STATES)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_load_vec   (w_load_vec),
        .i_load_pot   (w_load_pot),
        .i_item       (i_data),
        .i_num_states (r_num_states),
        .i_eps_floor  (r_eps_floor),
        .o_item       (o_data)
    );
endmodule

// ----- rtl/mpmu_div.sv -----
// ----------------------------------------------------------------------------
// mpmu_div
// Radix-2 restoring divider: (num << 16) / den, saturating to 32 bits.
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
module mpmu_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quot
);
    logic [47:0] r_dvd, n_dvd;
    logic [32:0] r_rem, n_rem;
    logic [47:0] r_quo, n_quo;
    logic [31:0] r_den, n_den;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [32:0] w_trial;

    // shift in one dividend bit, subtract when it fits
    always_comb begin
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_trial = {r_rem[31:0], r_dvd[47]};
        if (i_start) begin
            n_dvd  = {i_num, 16'd0};
            n_rem  = '0;
            n_quo  = '0;
            n_den  = i_den;
            n_cnt  = 6'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_dvd = {r_dvd[46:0], 1'b0};
            if (w_trial >= {1'b0, r_den}) begin
                n_rem = w_trial - {1'b0, r_den};
                n_quo = {r_quo[46:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_quo = {r_quo[46:0], 1'b0};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd47) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quot = (r_den == 32'd0 || r_quo[47:32] != 16'd0) ? 32'hFFFF_FFFF
                                                              : r_quo[31:0];
endmodule

// ----- rtl/mpmu_datapath.sv -----
// ----------------------------------------------------------------------------
// mpmu_datapath
// Stores, divider, multiplier and running max of the message update.
// ----------------------------------------------------------------------------
module mpmu_datapath #(
    parameter int MAX_STATES = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mpmu_pkg::t_cmd       i_cmd,
    output mpmu_pkg::t_sts       o_sts,
    input  logic                 i_load_vec,
    input  logic                 i_load_pot,
    input  mpmu_pkg::t_in_item   i_item,
    input  logic [4:0]           i_num_states,
    input  logic [15:0]          i_eps_floor,
    output mpmu_pkg::t_out_item  o_item
);
    import mpmu_pkg::*;

    localparam int IW = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
    localparam int PD = MAX_STATES * MAX_STATES;

    logic [31:0] r_belief [MAX_STATES];
    logic [31:0] r_oldmsg [MAX_STATES];
    logic [31:0] r_pot    [PD];
    logic [31:0] r_temp   [MAX_STATES];
    logic [31:0] r_newmsg [MAX_STATES];

    logic [IW-1:0] r_x, r_y;
    logic [IW:0]   w_n;
    logic [31:0]   r_bel_rd, r_old_rd, r_pot_rd, r_tmp_rd, r_new_rd;
    logic [63:0]   r_prod;
    logic [31:0]   r_best, r_peak;
    logic [31:0]   w_eps, w_den, w_prod_sat, w_num, w_div_den, w_quot;
    logic          w_div_start, w_div_done, w_zero;
    logic          r_div_go, r_div_sel_tmp;
    logic [IW+IW-1:0] w_pot_wa, w_pot_ra;

    // clamp state count to 2..MAX_STATES
    always_comb begin
        if ({1'b0, i_num_states} < 6'd2)
            w_n = (IW+1)'(2);
        else if (32'(i_num_states) > 32'(MAX_STATES))
            w_n = (IW+1)'(MAX_STATES);
        else
            w_n = (IW+1)'(i_num_states);
    end

    assign w_eps = (i_eps_floor == 16'd0) ? 32'd1 : {16'd0, i_eps_floor};
    assign w_den = (r_old_rd > w_eps) ? r_old_rd : w_eps;
    assign w_pot_wa = {i_item.row[IW-1:0], i_item.col[IW-1:0]};
    assign w_pot_ra = {r_y, r_x};

    // load writes
    always_ff @(posedge i_clk) begin
        if (i_load_vec && 32'(i_item.row) < 32'(MAX_STATES)) begin
            r_belief[i_item.row[IW-1:0]] <= i_item.belief_value;
            r_oldmsg[i_item.row[IW-1:0]] <= i_item.old_message;
        end
        if (i_load_pot && 32'(i_item.row) < 32'(MAX_STATES)
                       && 32'(i_item.col) < 32'(MAX_STATES))
            r_pot[w_pot_wa] <= i_item.potential;
    end

    // registered reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.tmp_rd) begin
            r_bel_rd <= r_belief[r_x];
            r_old_rd <= r_oldmsg[r_x];
        end
        if (i_cmd.mac_rd) begin
            r_pot_rd <= r_pot[w_pot_ra];
            r_tmp_rd <= r_temp[r_x];
        end
        if (i_cmd.nrm_rd)
            r_new_rd <= r_newmsg[r_y];
        if (i_cmd.tmp_wr)
            r_temp[r_x] <= w_quot;
    end

    // new message store, zero at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_STATES; i++)
                r_newmsg[i] <= '0;
        end else if (i_cmd.row_wr) begin
            r_newmsg[r_y] <= r_best;
        end else if (i_cmd.emit_load) begin
            r_newmsg[r_y] <= w_zero ? 32'd0 : w_quot;
        end
    end

    // product, running max, peak
    assign w_prod_sat = (r_prod[63:48] != 16'd0) ? 32'hFFFF_FFFF : r_prod[47:16];
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en)
            r_prod <= 64'(r_tmp_rd) * 64'(r_pot_rd);
        if (i_cmd.clr_x)
            r_best <= '0;
        else if (i_cmd.cmp_en && w_prod_sat > r_best)
            r_best <= w_prod_sat;
        if (i_cmd.clr_peak)
            r_peak <= '0;
        else if (i_cmd.row_wr && r_best > r_peak)
            r_peak <= r_best;
    end

    // state counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
            r_y <= '0;
        end else begin
            if (i_cmd.clr_x)      r_x <= '0;
            else if (i_cmd.inc_x) r_x <= r_x + IW'(1);
            if (i_cmd.clr_y)      r_y <= '0;
            else if (i_cmd.inc_y) r_y <= r_y + IW'(1);
        end
    end

    // delay the divider start until the read operands have landed
    assign w_div_start = i_cmd.div_start_tmp | i_cmd.div_start_nrm;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_go      <= 1'b0;
            r_div_sel_tmp <= 1'b0;
        end else begin
            r_div_go <= w_div_start;
            if (w_div_start)
                r_div_sel_tmp <= i_cmd.div_start_tmp;
        end
    end

    // shared divider
    assign w_num       = r_div_sel_tmp ? r_bel_rd : r_new_rd;
    assign w_div_den   = r_div_sel_tmp ? w_den : r_peak;

    mpmu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (w_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_zero = (r_peak == 32'd0);

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_load) begin
            o_item.state_index   <= 4'(r_y);
            o_item.message_value <= w_zero ? 32'd0 : w_quot;
            o_item.last          <= ({1'b0, r_y} == w_n - (IW+1)'(1));
            o_item.zero_peak     <= w_zero;
        end
    end

    assign o_sts.x_last   = ({1'b0, r_x} == w_n - (IW+1)'(1));
    assign o_sts.y_last   = ({1'b0, r_y} == w_n - (IW+1)'(1));
    assign o_sts.div_done = w_div_done;
endmodule

// ----- rtl/mpmu_ctrl.sv -----
// ----------------------------------------------------------------------------
// mpmu_ctrl
// Sequencer for the compute pass: quotients, max-product rows, normalize.
// ----------------------------------------------------------------------------
module mpmu_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_out_ready,
    input  mpmu_pkg::t_sts  i_sts,
    output mpmu_pkg::t_cmd  o_cmd,
    output logic            o_idle,
    output logic            o_out_valid
);
    import mpmu_pkg::*;

    t_state r_state, n_state;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:    if (i_start) n_state = ST_TMP_RD;
            ST_TMP_RD:  n_state = ST_TMP_DIV;
            ST_TMP_DIV: begin
                if (i_sts.div_done)
                    n_state = i_sts.x_last ? ST_MAC_RD : ST_TMP_RD;
            end
            ST_MAC_RD:  n_state = ST_MAC_MUL;
            ST_MAC_MUL: n_state = ST_MAC_CMP;
            ST_MAC_CMP: n_state = i_sts.x_last ? ST_ROW_END : ST_MAC_RD;
            ST_ROW_END: n_state = i_sts.y_last ? ST_NRM_RD : ST_MAC_RD;
            ST_NRM_RD:  n_state = ST_NRM_DIV;
            ST_NRM_DIV: if (i_sts.div_done) n_state = ST_EMIT;
            ST_EMIT: begin
                if (i_out_ready)
                    n_state = i_sts.y_last ? ST_IDLE : ST_NRM_RD;
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd       = '0;
        o_idle      = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_idle = 1'b1;
                if (i_start) begin
                    o_cmd.clr_x    = 1'b1;
                    o_cmd.clr_y    = 1'b1;
                    o_cmd.clr_peak = 1'b1;
                end
            end
            ST_TMP_RD:  o_cmd.tmp_rd = 1'b1;
            ST_TMP_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.tmp_wr = 1'b1;
                    if (i_sts.x_last) o_cmd.clr_x = 1'b1;
                    else              o_cmd.inc_x = 1'b1;
                end
            end
            ST_MAC_RD:  o_cmd.mac_rd = 1'b1;
            ST_MAC_MUL: o_cmd.mul_en = 1'b1;
            ST_MAC_CMP: begin
                o_cmd.cmp_en = 1'b1;
                if (!i_sts.x_last) o_cmd.inc_x = 1'b1;
            end
            ST_ROW_END: begin
                o_cmd.row_wr = 1'b1;
                o_cmd.clr_x  = 1'b1;
                if (i_sts.y_last) o_cmd.clr_y = 1'b1;
                else              o_cmd.inc_y = 1'b1;
            end
            ST_NRM_RD:  o_cmd.nrm_rd = 1'b1;
            ST_NRM_DIV: begin
                if (i_sts.div_done) o_cmd.emit_load = 1'b1;
            end
            ST_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready && !i_sts.y_last) o_cmd.inc_y = 1'b1;
            end
            default: ;
        endcase
        // request the divider start in the same cycle as the operand read; the datapath registers it
        if (r_state == ST_TMP_RD) o_cmd.div_start_tmp = 1'b1;
        if (r_state == ST_NRM_RD) o_cmd.div_start_nrm = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end
endmodule
